@@ hw/rtl/ewh_pkg.sv @@
// Shared types and constants for the equal-width histogram.
// No dependencies.
package ewh_pkg;

    localparam int MaxBinsDefault = 64;

    localparam logic [1:0] ActAdd    = 2'd0;
    localparam logic [1:0] ActDump   = 2'd1;
    localparam logic [1:0] ActClear  = 2'd2;
    localparam logic [1:0] ActIgnore = 2'd3;

    localparam logic [1:0] KindAck   = 2'd0;
    localparam logic [1:0] KindDump  = 2'd1;
    localparam logic [1:0] KindClear = 2'd2;

    localparam logic [1:0] RegMin  = 2'd0;
    localparam logic [1:0] RegMax  = 2'd1;
    localparam logic [1:0] RegBins = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  bin_index;
        logic [31:0] bin_total;
        logic        out_of_range;
        logic        last;
    } out_item_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;      // capture input item and config
        logic div_start; // start bin division
        logic div_step;  // one quotient bit
        logic mem_rd;    // read store at addr_reg
        logic mem_wr;    // write incremented count
        logic clr_wr;    // write zero at addr_reg
        logic addr_clr;  // addr_reg <= 0
        logic addr_inc;  // addr_reg <= addr_reg + 1
    } ewh_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic div_done;
        logic bad;       // sample flagged
        logic addr_last; // addr at last bin of dump
        logic clr_last;  // addr at last entry of store
    } ewh_sts_t;

endpackage

@@ hw/rtl/ewh_datapath.sv @@
// Datapath: config registers, bin divider, count store, read register.
// Depends on ewh_pkg.
module ewh_datapath #(
    parameter int MAX_BINS = ewh_pkg::MaxBinsDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  ewh_pkg::in_item_t   in_item,
    input  ewh_pkg::ewh_cmd_t   cmd,
    output ewh_pkg::ewh_sts_t   sts,
    output logic [1:0]          act,
    output logic [5:0]          cur_addr,
    output logic [31:0]         rd_data
);
    import ewh_pkg::*;

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam logic [6:0] MaxB = 7'(MAX_BINS);

    logic signed [15:0] min_reg, max_reg;
    logic [6:0]         bins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= 16'sd0;
            max_reg  <= 16'sd100;
            bins_reg <= 7'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegMin:  min_reg  <= cfg_data[15:0];
                RegMax:  max_reg  <= cfg_data[15:0];
                RegBins: bins_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [6:0] nb;
    assign nb = (bins_reg > MaxB) ? MaxB : bins_reg;

    // Captured item
    logic [1:0]  act_reg;
    logic        bad_reg;
    logic [6:0]  nb_reg;
    logic [48:0] span_reg;   // (max-min)<<16, fits 33 bits, padded
    logic [48:0] rem_reg;    // partial remainder
    logic [38:0] num_reg;    // diff*nb, shifted out msb first
    logic [5:0]  quo_clamp;
    logic [5:0]  step_reg;
    logic [5:0]  addr_reg;

    logic signed [32:0] v_ext, lo_ext, hi_ext;
    logic [32:0]        diff_w;
    logic               bad_w;
    assign v_ext  = 33'(in_item.sample_value);
    assign lo_ext = {min_reg[15], min_reg, 16'd0};
    assign hi_ext = {max_reg[15], max_reg, 16'd0};
    assign bad_w  = (max_reg <= min_reg) || (nb == 7'd0) || (v_ext < lo_ext)
                    || (v_ext > hi_ext);
    assign diff_w = 33'(v_ext - lo_ext);

    // Restoring divide, one quotient bit a cycle over 39 numerator bits.
    // Quotient fits in 7 bits (<= nb); only the low 6 kept after clamp.
    logic [6:0]  quo_full;
    logic [49:0] trial;
    logic [48:0] rem_sh;
    assign rem_sh = {rem_reg[47:0], num_reg[38]};
    assign trial  = {1'b0, rem_sh} - {1'b0, span_reg};

    logic [6:0] qf_reg;
    assign quo_full = qf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= ActAdd;
            step_reg <= '0;
            addr_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                act_reg <= in_item.action;
            if (cmd.div_start)
                step_reg <= 6'd39;
            else if (cmd.div_step)
                step_reg <= step_reg - 6'd1;
            if (cmd.addr_clr)
                addr_reg <= '0;
            else if (cmd.addr_inc)
                addr_reg <= addr_reg + 6'd1;
            else if (cmd.div_step && step_reg == 6'd1)
                addr_reg <= quo_clamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bad_reg  <= bad_w;
            nb_reg   <= nb;
            span_reg <= {16'd0, 33'(hi_ext - lo_ext)};
            num_reg  <= {6'd0, diff_w} * 39'(nb);
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            qf_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[37:0], 1'b0};
            if (!trial[49])
            begin
                rem_reg <= trial[48:0];
                qf_reg  <= {qf_reg[5:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                qf_reg  <= {qf_reg[5:0], 1'b0};
            end
        end
    end

    // Clamp quotient into [0, nb-1]; next quotient bit folded in.
    logic [6:0] q_next;
    assign q_next = {quo_full[5:0], ~trial[49]};
    always_comb
    begin
        quo_clamp = (q_next >= nb_reg) ? 6'(nb_reg - 7'd1) : q_next[5:0];
    end

    // Count store
    logic [31:0] mem [MAX_BINS];
    logic [31:0] rd_q;
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            mem[addr_reg[AW-1:0]] <= '0;
        else if (cmd.mem_wr)
            mem[addr_reg[AW-1:0]] <= (rd_q == 32'hFFFF_FFFF) ? rd_q : rd_q + 32'd1;
        if (cmd.mem_rd)
            rd_q <= mem[addr_reg[AW-1:0]];
    end

    assign rd_data  = rd_q;
    assign act      = act_reg;
    assign cur_addr = addr_reg;
    assign sts.div_done  = (step_reg == 6'd0);
    assign sts.bad       = bad_reg;
    assign sts.addr_last = (7'(addr_reg) + 7'd1 >= nb_reg);
    assign sts.clr_last  = (7'(addr_reg) == MaxB - 7'd1);
endmodule

@@ hw/rtl/ewh_ctrl.sv @@
// Controller state machine for the histogram: sequences add, dump, clear.
// Depends on ewh_pkg.
module ewh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ewh_pkg::out_item_t  out_data,
    output ewh_pkg::ewh_cmd_t   cmd,
    input  ewh_pkg::ewh_sts_t   sts,
    input  logic [1:0]          act,
    input  logic [5:0]          cur_addr,
    input  logic [31:0]         rd_data,
    input  logic [1:0]          in_action
);
    import ewh_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StDec  = 3'd1;
    localparam logic [2:0] StDiv  = 3'd2;
    localparam logic [2:0] StRd   = 3'd3;
    localparam logic [2:0] StUpd  = 3'd4;
    localparam logic [2:0] StDump = 3'd5;
    localparam logic [2:0] StClr  = 3'd6;
    localparam logic [2:0] StRdD  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       init_reg, init_next;  // clear pass after reset, no result
    out_item_t  od_reg, od_next;
    logic       out_free;

    assign out_free  = !ov_reg || out_ready;
    assign in_ready  = (state_reg == StIdle);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;
        init_next  = init_reg;
        cmd        = '0;
        case (state_reg)
            StIdle:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.addr_clr = 1'b1;
                    if (in_action != ActIgnore)
                        state_next = StDec;
                end
            end
            StDec:
            begin
                case (act)
                    ActAdd:
                    begin
                        cmd.div_start = 1'b1;
                        state_next = sts.bad ? StUpd : StDiv;
                    end
                    ActDump:
                    begin
                        cmd.mem_rd = 1'b1;
                        state_next = StRdD;
                    end
                    default: state_next = StClr;
                endcase
            end
            StDiv:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.div_step = 1'b0;
                    cmd.mem_rd   = 1'b1;
                    state_next   = StRd;
                end
            end
            StRd: state_next = StUpd;
            StUpd:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    od_next.kind = KindAck;
                    od_next.last = 1'b1;
                    if (sts.bad)
                    begin
                        od_next.bin_index    = '0;
                        od_next.bin_total    = '0;
                        od_next.out_of_range = 1'b1;
                    end
                    else
                    begin
                        cmd.mem_wr = 1'b1;
                        od_next.bin_index    = cur_addr;
                        od_next.bin_total    = (rd_data == 32'hFFFF_FFFF) ? rd_data
                                               : rd_data + 32'd1;
                        od_next.out_of_range = 1'b0;
                    end
                    state_next = StIdle;
                end
            end
            StRdD: state_next = StDump;
            StDump:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    od_next.kind         = KindDump;
                    od_next.bin_index    = cur_addr;
                    od_next.bin_total    = rd_data;
                    od_next.out_of_range = 1'b0;
                    od_next.last         = sts.addr_last;
                    if (sts.addr_last)
                        state_next = StIdle;
                    else
                    begin
                        cmd.addr_inc = 1'b1;
                        state_next   = StDec;
                    end
                end
            end
            StClr:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        state_next = StIdle;
                    end
                    else if (out_free)
                    begin
                        ov_next = 1'b1;
                        od_next.kind         = KindClear;
                        od_next.bin_index    = '0;
                        od_next.bin_total    = '0;
                        od_next.out_of_range = 1'b0;
                        od_next.last         = 1'b1;
                        state_next = StIdle;
                    end
                end
                else
                    cmd.addr_inc = 1'b1;
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StClr;
            ov_reg    <= 1'b0;
            init_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            init_reg  <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == StIdle)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_wr && cmd.clr_wr))
        else $error("write conflict");
endmodule

@@ hw/rtl/equal_width_histogram.sv @@
// Equal-width histogram top level: controller plus datapath.
// Depends on ewh_pkg, ewh_ctrl, ewh_datapath.
//
// Usage: in_valid/in_ready carry one transaction (action, sample_value).
// Add sample: a 39-step restoring divider forms floor(diff*bins/span),
// clamped to bins-1, then the count store is read and written back; one
// result per sample, and an out-of-range sample skips both. Dump: one
// result per bin, the last marked. Clear: one store entry zeroed per
// cycle, then one result. Action 3 gives no result.
// Items are taken one at a time; in_ready is high only while idle.
// A result register holds the output; if the receiver stalls, work stops
// at the next result until out_ready. Reset loads min 0, max 100, bins 10.
// cfg_valid/cfg_ready write one register (index 0 min, 1 max, 2 bins);
// cfg_ready is always high. The store is cleared at reset by an
// initial clear pass run before the first item.
module equal_width_histogram #(
    parameter int MAX_BINS = ewh_pkg::MaxBinsDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ewh_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ewh_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import ewh_pkg::*;

    ewh_cmd_t    cmd;
    ewh_sts_t    sts;
    logic [1:0]  act;
    logic [5:0]  cur_addr;
    logic [31:0] rd_data;

    assign cfg_ready = 1'b1;

    ewh_datapath #(.MAX_BINS(MAX_BINS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_item(in_data), .cmd(cmd), .sts(sts),
        .act(act), .cur_addr(cur_addr), .rd_data(rd_data)
    );

    ewh_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cmd(cmd), .sts(sts), .act(act), .cur_addr(cur_addr),
        .rd_data(rd_data), .in_action(in_data.action)
    );
endmodule
